>>> src/bdar_pkg.sv
// ----------------------------------------------------------------------------
// bdar_pkg
// Shared types and constants for the button debounce / auto-repeat block.
// ----------------------------------------------------------------------------
package bdar_pkg;

    localparam int TIME_W = 32;

    // Button mode, also the encoding of the event_mode result field
    typedef enum logic [1:0] {
        MODE_UP      = 2'd0,
        MODE_LATCHED = 2'd1,
        MODE_FIRST   = 2'd2,
        MODE_REPEAT  = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_DEBOUNCE = 2'd0;
    localparam reg_idx_t REG_HOLD     = 2'd1;
    localparam reg_idx_t REG_PERIOD   = 2'd2;

    // Register reset values
    localparam logic [TIME_W-1:0] DEBOUNCE_RST = 32'd50;
    localparam logic [TIME_W-1:0] HOLD_RST     = 32'd500;
    localparam logic [TIME_W-1:0] PERIOD_RST   = 32'd100;

    // Outcome of one step: event flag, mode after the step, latch-time reload
    typedef struct packed {
        logic  notify;
        mode_t mode;
        logic  load_time;
    } step_t;

endpackage

>>> src/bdar_step.sv
// ----------------------------------------------------------------------------
// bdar_step
// Next-state logic for one word: mode transitions and timer expiry check.
// ----------------------------------------------------------------------------
module bdar_step (
    input  bdar_pkg::mode_t               mode,
    input  logic [bdar_pkg::TIME_W-1:0]   latch_time,
    input  logic                          action,
    input  logic                          pin_low,
    input  logic [bdar_pkg::TIME_W-1:0]   now_ms,
    input  logic [bdar_pkg::TIME_W-1:0]   debounce_ms,
    input  logic [bdar_pkg::TIME_W-1:0]   hold_ms,
    input  logic [bdar_pkg::TIME_W-1:0]   repeat_period_ms,
    output bdar_pkg::step_t               step
);

    logic [bdar_pkg::TIME_W-1:0] limit;
    logic [bdar_pkg::TIME_W-1:0] elapsed;
    logic                        over;

    // One subtract and compare, shared by all timers
    always_comb begin
        case (mode)
            bdar_pkg::MODE_LATCHED: limit = debounce_ms;
            bdar_pkg::MODE_FIRST:   limit = hold_ms;
            default:                limit = repeat_period_ms;
        endcase
    end

    assign elapsed = now_ms - latch_time;
    assign over    = elapsed > limit;

    always_comb begin
        step.notify    = 1'b0;
        step.mode      = mode;
        step.load_time = 1'b0;
        if (action) begin
            // edge: latch only from up
            if (mode == bdar_pkg::MODE_UP) begin
                step.mode      = bdar_pkg::MODE_LATCHED;
                step.load_time = 1'b1;
            end
        end else begin
            case (mode)
                bdar_pkg::MODE_LATCHED: begin
                    if (over) begin
                        step.notify = 1'b1;
                        if (pin_low) begin
                            step.mode      = bdar_pkg::MODE_FIRST;
                            step.load_time = 1'b1;
                        end else begin
                            step.mode = bdar_pkg::MODE_UP;
                        end
                    end
                end
                bdar_pkg::MODE_FIRST: begin
                    if (!pin_low) begin
                        step.mode   = bdar_pkg::MODE_UP;
                        step.notify = 1'b1;
                    end else if (hold_ms != '0 && over) begin
                        step.mode      = bdar_pkg::MODE_REPEAT;
                        step.load_time = 1'b1;
                        step.notify    = 1'b1;
                    end
                end
                bdar_pkg::MODE_REPEAT: begin
                    if (!pin_low) begin
                        step.mode   = bdar_pkg::MODE_UP;
                        step.notify = 1'b1;
                    end else if (repeat_period_ms != '0 && over) begin
                        step.load_time = 1'b1;
                        step.notify    = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> src/button_debounce_auto_repeat.sv
// ----------------------------------------------------------------------------
// button_debounce_auto_repeat
// Active-low push-button qualifier with debounce and auto-repeat.
// ----------------------------------------------------------------------------
// Each input word is either a falling edge seen on the pin (s_tuser = 1) or a
// poll (s_tuser = 0), carrying the pin level and the current millisecond time.
// Every input word produces exactly one result word: the notify flag, the mode
// after the step (0 up, 1 latched, 2 first, 3 repeat) and a pressed flag. An
// edge while up latches the time; polls promote latched to first after the
// debounce time if the pin is still low (else back to up), first to repeat
// after the hold time and in repeat raise an event every repeat period (each
// only if nonzero); in first or repeat a release seen by a poll returns to up.
// Time differences wrap modulo 2^32 and every comparison is strictly greater.
// Throughput is one word per clock unless m_tready stalls the result. A word
// is captured in the input register and moves to the result register, which
// drives m_tvalid, once that register is free or being drained. The mode and
// latch time update in the same cycle the result register loads, so the next
// word sees them at once. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module button_debounce_auto_repeat (
    input  logic                         aclk,
    input  logic                         aresetn,

    // Input words
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [39:0]                  s_tdata,   // [0] pin_low, [32:1] now_ms, rest zero
    input  logic                         s_tuser,   // [0] action

    // Result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // [0] notify, [2:1] event_mode,
                                                    // [3] pressed, rest zero

    // Configuration writes
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  bdar_pkg::reg_idx_t           cfg_index,
    input  logic [bdar_pkg::TIME_W-1:0]  cfg_data
);

    // Configuration registers
    logic [bdar_pkg::TIME_W-1:0] debounce_reg;
    logic [bdar_pkg::TIME_W-1:0] hold_reg;
    logic [bdar_pkg::TIME_W-1:0] period_reg;

    // Input register
    logic                        in_valid_reg;
    logic                        action_reg;
    logic                        pin_low_reg;
    logic [bdar_pkg::TIME_W-1:0] now_reg;

    // Block state
    bdar_pkg::mode_t             mode_reg;
    logic [bdar_pkg::TIME_W-1:0] latch_time_reg;

    // Result register
    logic                        out_valid_reg;
    logic                        notify_reg;
    bdar_pkg::mode_t             out_mode_reg;

    bdar_pkg::step_t             step;
    logic                        advance;

    // Advance the input word when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // Configuration: out-of-range indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= bdar_pkg::DEBOUNCE_RST;
            hold_reg     <= bdar_pkg::HOLD_RST;
            period_reg   <= bdar_pkg::PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                bdar_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                bdar_pkg::REG_HOLD:     hold_reg     <= cfg_data;
                bdar_pkg::REG_PERIOD:   period_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg  <= s_tuser;
            pin_low_reg <= s_tdata[0];
            now_reg     <= s_tdata[bdar_pkg::TIME_W:1];
        end
    end

    bdar_step u_step (
        .mode             (mode_reg),
        .latch_time       (latch_time_reg),
        .action           (action_reg),
        .pin_low          (pin_low_reg),
        .now_ms           (now_reg),
        .debounce_ms      (debounce_reg),
        .hold_ms          (hold_reg),
        .repeat_period_ms (period_reg),
        .step             (step)
    );

    // Update the mode and latch time as the word moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= bdar_pkg::MODE_UP;
            latch_time_reg <= '0;
        end else if (advance) begin
            mode_reg <= step.mode;
            if (step.load_time) begin
                latch_time_reg <= now_reg;
            end
        end
    end

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            notify_reg   <= step.notify;
            out_mode_reg <= step.mode;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, (out_mode_reg != bdar_pkg::MODE_UP), out_mode_reg, notify_reg};

endmodule
